>>> hdl/wts_pkg.sv
`timescale 1ns / 1ps

package wts_pkg;

  // Texture store geometry
  localparam int STORE_BYTES = 65536;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int BYTE_W      = 8;

  // Texture dimensions and texel indices
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = 13;
  localparam int COL_W   = $clog2(MAX_DIM);
  localparam int CH_W    = 3;

  // Coordinates and fractions
  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;

  // Weights, accumulators and the final scaling by 1 / (255 * 2^18)
  localparam int WT_W        = 2 * FRAC_W + 1;
  localparam int ACC_W       = 2 * FRAC_W + BYTE_W;
  localparam int ACC_SHIFT   = 18;
  localparam int DIVD_W      = ACC_W - ACC_SHIFT;
  localparam int RECIP_W     = 25;
  localparam logic [RECIP_W-1:0] RECIP = 25'h101_0102;
  localparam int RECIP_SHIFT = 32;
  localparam int QUO_W       = 15;
  localparam int OUT_W       = 16;
  localparam int QUO_MAX     = 16384;

  // Gather sequence
  localparam int TEXELS    = 4;
  localparam int CHANNELS  = 3;
  localparam int TEXEL_W   = $clog2(TEXELS);
  localparam int CHAN_W    = $clog2(CHANNELS);

  // Channel count codes
  localparam logic [CH_W-1:0] CH_GRAY = 3'd1;
  localparam logic [CH_W-1:0] CH_RGB  = 3'd3;
  localparam logic [CH_W-1:0] CH_RGBA = 3'd4;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH,
    REG_TEX_HEIGHT,
    REG_CHANNEL_COUNT
  } cfg_reg_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_e;

  // Controller to datapath
  typedef struct packed {
    logic               capture;
    logic               step_idx;
    logic               step_wrap;
    logic               step_row;
    logic               step_px;
    logic               issue;
    logic [TEXEL_W-1:0] texel;
    logic [CHAN_W-1:0]  chan;
    logic               load_out;
  } wts_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic black;
    logic out_free;
  } wts_stat_t;

endpackage

>>> hdl/wts_chan_if.sv
`timescale 1ns / 1ps

interface wts_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [wts_pkg::ADDR_W-1:0]    byte_address;
  logic [wts_pkg::BYTE_W-1:0]    byte_value;
  logic signed [wts_pkg::COORD_W-1:0] coord_u;
  logic signed [wts_pkg::COORD_W-1:0] coord_v;

  modport source (output valid, opcode, byte_address, byte_value, coord_u, coord_v,
                  input ready);
  modport sink (input valid, opcode, byte_address, byte_value, coord_u, coord_v,
                output ready);
endinterface

interface wts_out_if;
  logic                      valid;
  logic                      ready;
  logic                      is_sample;
  logic [wts_pkg::OUT_W-1:0] red;
  logic [wts_pkg::OUT_W-1:0] green;
  logic [wts_pkg::OUT_W-1:0] blue;

  modport source (output valid, is_sample, red, green, blue, input ready);
  modport sink (input valid, is_sample, red, green, blue, output ready);
endinterface

interface wts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wts_pkg::CFG_IDX_W-1:0]  index;
  logic [wts_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/wrapped_texture_sampler.sv
`timescale 1ns / 1ps

// Bilinear texture sampler with wrap-around addressing over a byte-wide store.
// Channels: in_chan_i carries items (opcode 0 writes byte_value to
// byte_address, opcode 1 samples at the fractional parts of coord_u/coord_v);
// out_chan_o returns one result per item; cfg_chan_i writes tex_width (0),
// tex_height (1) and channel_count (2), and is always ready.
// All channels transfer when valid and ready are both high.
// A write goes from its transfer straight to hand-over; a sample passes the
// setup steps (index, wrap, row, texel address), 12 byte reads, the drain
// states DRAIN1 and DRAIN2 and hand-over. The result is then held in the output
// register. One item is in flight at a time: a new item is taken only once
// the last has been loaded into the output register. The 12 reads go one byte
// per cycle through the single read port of the texture memory; black
// samples skip them.
// Reset clears the configuration registers to zero, returns the controller to
// idle and empties the result register; the texture memory is not cleared and
// holds undefined data until written. When the receiver stalls, the result is
// held in the output register; the next item is still taken and worked on, and
// waits at its end until the output register is free.

module wrapped_texture_sampler (
  input  logic      clk_i,
  input  logic      rst_ni,
  wts_in_if.sink    in_chan_i,
  wts_out_if.source out_chan_o,
  wts_cfg_if.sink   cfg_chan_i
);
  import wts_pkg::*;

  wts_cmd_t  cmd;
  wts_stat_t stat;
  logic      cfg_we;

  // Configuration writes are taken in any cycle
  assign cfg_chan_i.ready = 1'b1;
  assign cfg_we           = cfg_chan_i.valid;

  wts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan_i.valid),
    .in_sample_i (in_chan_i.opcode == OP_SAMPLE),
    .in_ready_o  (in_chan_i.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  wts_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_chan_i.index),
    .cfg_data_i        (cfg_chan_i.data),
    .in_opcode_i       (in_chan_i.opcode),
    .in_byte_address_i (in_chan_i.byte_address),
    .in_byte_value_i   (in_chan_i.byte_value),
    .in_coord_u_i      (in_chan_i.coord_u),
    .in_coord_v_i      (in_chan_i.coord_v),
    .out_ready_i       (out_chan_o.ready),
    .out_valid_o       (out_chan_o.valid),
    .out_is_sample_o   (out_chan_o.is_sample),
    .out_red_o         (out_chan_o.red),
    .out_green_o       (out_chan_o.green),
    .out_blue_o        (out_chan_o.blue)
  );

endmodule

>>> hdl/wts_ram.sv
`timescale 1ns / 1ps

module wts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/wts_ctrl.sv
`timescale 1ns / 1ps

module wts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_sample_i,
  output logic               in_ready_o,
  output wts_pkg::wts_cmd_t  cmd_o,
  input  wts_pkg::wts_stat_t stat_i
);
  import wts_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IDX,
    ST_WRAP,
    ST_ROW,
    ST_PX,
    ST_READ,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic               ready_q, ready_d;
  logic [TEXEL_W-1:0] texel_q, texel_d;
  logic [CHAN_W-1:0]  chan_q, chan_d;
  logic               accept;

  assign accept     = in_valid_i & ready_q;
  assign in_ready_o = ready_q;

  // Sequence one item through setup, gather, drain and hand-over; writes and black samples skip to hand-over
  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    texel_d = texel_q;
    chan_d  = chan_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ready_d = 1'b0;
          state_d = in_sample_i ? ST_IDX : ST_DONE;
        end
      end
      ST_IDX:  state_d = ST_WRAP;
      ST_WRAP: state_d = ST_ROW;
      ST_ROW:  state_d = ST_PX;
      ST_PX: begin
        texel_d = '0;
        chan_d  = '0;
        state_d = stat_i.black ? ST_DONE : ST_READ;
      end
      ST_READ: begin
        if (chan_q == CHAN_W'(CHANNELS - 1)) begin
          chan_d  = '0;
          texel_d = texel_q + 1'b1;
          if (texel_q == TEXEL_W'(TEXELS - 1)) begin
            state_d = ST_DRAIN1;
          end
        end else begin
          chan_d = chan_q + 1'b1;
        end
      end
      ST_DRAIN1: state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = ST_DONE;
      ST_DONE: begin
        if (stat_i.out_free) begin
          ready_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state, counters and the input ready flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
      texel_q <= '0;
      chan_q  <= '0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      texel_q <= texel_d;
      chan_q  <= chan_d;
    end
  end

  // Decode datapath commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = accept;
    cmd_o.step_idx  = (state_q == ST_IDX);
    cmd_o.step_wrap = (state_q == ST_WRAP);
    cmd_o.step_row  = (state_q == ST_ROW);
    cmd_o.step_px   = (state_q == ST_PX);
    cmd_o.issue     = (state_q == ST_READ);
    cmd_o.texel     = texel_q;
    cmd_o.chan      = chan_q;
    cmd_o.load_out  = (state_q == ST_DONE) & stat_i.out_free;
  end

endmodule

>>> hdl/wts_datapath.sv
`timescale 1ns / 1ps

module wts_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wts_pkg::wts_cmd_t              cmd_i,
  output wts_pkg::wts_stat_t             stat_o,
  input  logic                           cfg_we_i,
  input  logic [wts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wts_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_opcode_i,
  input  logic [wts_pkg::ADDR_W-1:0]     in_byte_address_i,
  input  logic [wts_pkg::BYTE_W-1:0]     in_byte_value_i,
  input  logic [wts_pkg::COORD_W-1:0]    in_coord_u_i,
  input  logic [wts_pkg::COORD_W-1:0]    in_coord_v_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic                           out_is_sample_o,
  output logic [wts_pkg::OUT_W-1:0]      out_red_o,
  output logic [wts_pkg::OUT_W-1:0]      out_green_o,
  output logic [wts_pkg::OUT_W-1:0]      out_blue_o
);
  import wts_pkg::*;

  localparam logic [FRAC_W:0] FRAC_ONE = {1'b1, {FRAC_W{1'b0}}};

  // Configuration registers
  logic [DIM_W-1:0] tex_width_q, tex_height_q;
  logic [CH_W-1:0]  channel_count_q;

  // Captured item
  logic              sample_q;
  logic [FRAC_W-1:0] fu_q, fv_q;
  logic [DIM_W-1:0]  w_q, h_q;
  logic [CH_W-1:0]   ch_q;
  logic              ch_valid;
  logic              gray;

  // Texel geometry
  logic [COL_W-1:0]  i_q, j_q, i1_q, j1_q;
  logic [ADDR_W-1:0] rb0_q, rb1_q;
  logic [ADDR_W-1:0] px_q [TEXELS];

  // Gather pipeline
  logic              v1_q, v2_q;
  logic [CHAN_W-1:0] ch1_q, ch2_q;
  logic [WT_W-1:0]   wt_s1_q;
  logic [ACC_W-1:0]  prod_q;
  logic [ACC_W-1:0]  acc_q [CHANNELS];

  // Result register
  logic              out_valid_q;
  logic              out_sample_q;
  logic [OUT_W-1:0]  out_col_q [CHANNELS];

  // Memory connections
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // Combinational terms
  logic [FRAC_W+DIM_W-1:0]  ipro, jpro;
  logic [DIM_W-1:0]         i_inc, j_inc;
  logic [COL_W+DIM_W-1:0]   rpro0, rpro1;
  logic [ADDR_W-1:0]        px_d [TEXELS];
  logic [FRAC_W:0]          wu, wv;
  logic [2*FRAC_W+1:0]      wpro;
  logic [WT_W+BYTE_W-1:0]   ppro;
  logic [OUT_W-1:0]         quo [CHANNELS];

  assign ch_valid = (ch_q == CH_GRAY) || (ch_q == CH_RGB) || (ch_q == CH_RGBA);
  assign gray     = (ch_q == CH_GRAY);

  assign stat_o.black    = (w_q == '0) || (h_q == '0) || !ch_valid;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q     <= '0;
      tex_height_q    <= '0;
      channel_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TEX_WIDTH:     tex_width_q     <= cfg_data_i;
        REG_TEX_HEIGHT:    tex_height_q    <= cfg_data_i;
        REG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Setup arithmetic
  always_comb begin
    ipro  = fu_q * w_q;
    jpro  = fv_q * h_q;
    i_inc = {1'b0, i_q} + DIM_W'(1);
    j_inc = {1'b0, j_q} + DIM_W'(1);
    rpro0 = j_q * w_q;
    rpro1 = j1_q * w_q;
    for (int k = 0; k < TEXELS; k++) begin
      logic [ADDR_W-1:0]      base;
      logic [ADDR_W+CH_W-1:0] ppx;
      base    = (k / 2 == 0 ? rb0_q : rb1_q) + ADDR_W'(k % 2 == 0 ? i_q : i1_q);
      ppx     = base * ch_q;
      px_d[k] = ppx[ADDR_W-1:0];
    end
  end

  // Capture the item and step through the texel geometry
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= (in_opcode_i == OP_SAMPLE);
      fu_q     <= in_coord_u_i[FRAC_W-1:0];
      fv_q     <= in_coord_v_i[FRAC_W-1:0];
      w_q      <= (tex_width_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : tex_width_q;
      h_q      <= (tex_height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : tex_height_q;
      ch_q     <= channel_count_q;
    end
    if (cmd_i.step_idx) begin
      i_q <= ipro[FRAC_W +: COL_W];
      j_q <= jpro[FRAC_W +: COL_W];
    end
    if (cmd_i.step_wrap) begin
      i1_q <= (i_inc >= w_q) ? '0 : i_inc[COL_W-1:0];
      j1_q <= (j_inc >= h_q) ? '0 : j_inc[COL_W-1:0];
    end
    if (cmd_i.step_row) begin
      rb0_q <= rpro0[ADDR_W-1:0];
      rb1_q <= rpro1[ADDR_W-1:0];
    end
    if (cmd_i.step_px) begin
      for (int k = 0; k < TEXELS; k++) begin
        px_q[k] <= px_d[k];
      end
    end
  end

  // Byte address and texel weight for the current read
  always_comb begin
    ram_we    = cmd_i.capture && (in_opcode_i == OP_WRITE);
    ram_raddr = px_q[cmd_i.texel] + (gray ? '0 : ADDR_W'(cmd_i.chan));
    wu        = cmd_i.texel[0] ? {1'b0, fu_q} : FRAC_ONE - {1'b0, fu_q};
    wv        = cmd_i.texel[1] ? {1'b0, fv_q} : FRAC_ONE - {1'b0, fv_q};
    wpro      = wu * wv;
    ppro      = wt_s1_q * ram_rdata;
  end

  wts_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_byte_address_i),
    .wdata_i (in_byte_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Advance pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  // Weight, weighted byte and channel accumulators
  always_ff @(posedge clk_i) begin
    wt_s1_q <= wpro[WT_W-1:0];
    ch1_q   <= cmd_i.chan;
    prod_q  <= ppro[ACC_W-1:0];
    ch2_q   <= ch1_q;
    for (int c = 0; c < CHANNELS; c++) begin
      if (cmd_i.capture) begin
        acc_q[c] <= '0;
      end else if (v2_q && ch2_q == CHAN_W'(c)) begin
        acc_q[c] <= acc_q[c] + prod_q;
      end
    end
  end

  // Scale by 1 / (255 * 2^18): shift, then multiply by the rounded-up reciprocal of 255
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      logic [DIVD_W+RECIP_W-1:0] qpro;
      qpro   = acc_q[c][ACC_W-1:ACC_SHIFT] * RECIP;
      quo[c] = OUT_W'(qpro[RECIP_SHIFT +: QUO_W]);
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_sample_q <= sample_q;
      for (int c = 0; c < CHANNELS; c++) begin
        out_col_q[c] <= quo[c];
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_is_sample_o = out_sample_q;
  assign out_red_o       = out_col_q[0];
  assign out_green_o     = out_col_q[1];
  assign out_blue_o      = out_col_q[2];

endmodule

>>> hdl/wts_checker.sv
`timescale 1ns / 1ps

module wts_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_opcode_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      out_is_sample_i,
  input logic [wts_pkg::OUT_W-1:0] out_red_i,
  input logic [wts_pkg::OUT_W-1:0] out_green_i,
  input logic [wts_pkg::OUT_W-1:0] out_blue_i
);
  import wts_pkg::*;

  // One item at a time: a transfer drops ready for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready stayed high after a transfer");

  // A write accepted while the output register is empty goes through hand-over into it as a write result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_opcode_i == OP_WRITE && !out_valid_i
    |-> ##2 (out_valid_i && !out_is_sample_i))
    else $error("write result not delivered on time");

  // Write results carry black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_is_sample_i |->
      out_red_i == '0 && out_green_i == '0 && out_blue_i == '0)
    else $error("write result carries colour");

  // Sample colours never exceed one quarter of full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_red_i <= OUT_W'(QUO_MAX) && out_green_i <= OUT_W'(QUO_MAX)
      && out_blue_i <= OUT_W'(QUO_MAX))
    else $error("colour out of range");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_red_i)
      && $stable(out_green_i) && $stable(out_blue_i) && $stable(out_is_sample_i))
    else $error("stalled result changed");

endmodule

bind wrapped_texture_sampler wts_checker u_wts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_chan_i.valid),
  .in_ready_i      (in_chan_i.ready),
  .in_opcode_i     (in_chan_i.opcode),
  .out_valid_i     (out_chan_o.valid),
  .out_ready_i     (out_chan_o.ready),
  .out_is_sample_i (out_chan_o.is_sample),
  .out_red_i       (out_chan_o.red),
  .out_green_i     (out_chan_o.green),
  .out_blue_i      (out_chan_o.blue)
);

>>> dv/tb_wrapped_texture_sampler.sv
`timescale 1ns / 1ps

import wts_pkg::*;

typedef struct {
  opcode_e                    op;
  logic [ADDR_W-1:0]          addr;
  logic [BYTE_W-1:0]          value;
  logic signed [COORD_W-1:0]  u;
  logic signed [COORD_W-1:0]  v;
} tex_item_t;

typedef struct {
  logic             is_sample;
  logic [OUT_W-1:0] red;
  logic [OUT_W-1:0] green;
  logic [OUT_W-1:0] blue;
} colour_t;

// Mirror of the texture store and registers; predicts and checks colours
class texture_mirror;
  logic [BYTE_W-1:0] store_copy [STORE_BYTES];
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;
  logic [CH_W-1:0]   chans_q;
  colour_t           pending_colours[$];
  int unsigned       results_seen;
  int unsigned       mismatches;

  function new();
    width_q      = '0;
    height_q     = '0;
    chans_q      = '0;
    results_seen = 0;
    mismatches   = 0;
  endfunction

  // List the store bytes a sample reads, three per texel, texel-major; empty when black
  static function void texel_addresses(int unsigned w, int unsigned h, logic [CH_W-1:0] ch,
                                       logic [FRAC_W-1:0] fu, logic [FRAC_W-1:0] fv,
                                       output int unsigned addrs[$]);
    int unsigned wc, hc, cn, i, j, i1, j1, k, c;
    int unsigned base [TEXELS];
    addrs = {};
    wc = (w > MAX_DIM) ? MAX_DIM : w;
    hc = (h > MAX_DIM) ? MAX_DIM : h;
    if (wc == 0 || hc == 0 || !(ch == CH_GRAY || ch == CH_RGB || ch == CH_RGBA)) return;
    cn = ch;
    i  = (fu * wc) >> FRAC_W;
    j  = (fv * hc) >> FRAC_W;
    i1 = (i + 1 >= wc) ? 0 : i + 1;
    j1 = (j + 1 >= hc) ? 0 : j + 1;
    base[0] = (j * wc + i) * cn;
    base[1] = (j * wc + i1) * cn;
    base[2] = (j1 * wc + i) * cn;
    base[3] = (j1 * wc + i1) * cn;
    for (k = 0; k < TEXELS; k++) begin
      for (c = 0; c < CHANNELS; c++) begin
        addrs.push_back((base[k] + ((ch == CH_GRAY) ? 0 : c)) % STORE_BYTES);
      end
    end
  endfunction

  // Weight the four texels by the fractions and scale down to Q2.14
  function colour_t blend(logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
    colour_t         res;
    int unsigned     addrs[$];
    longint unsigned fu, fv, k, c;
    longint unsigned wt [TEXELS];
    longint unsigned acc [CHANNELS];
    res = '{1'b1, '0, '0, '0};
    texel_addresses(width_q, height_q, chans_q, u[FRAC_W-1:0], v[FRAC_W-1:0], addrs);
    if (addrs.size() == 0) return res;
    fu = u[FRAC_W-1:0];
    fv = v[FRAC_W-1:0];
    wt[0] = (65536 - fu) * (65536 - fv);
    wt[1] = fu * (65536 - fv);
    wt[2] = (65536 - fu) * fv;
    wt[3] = fu * fv;
    for (c = 0; c < CHANNELS; c++) acc[c] = 0;
    for (k = 0; k < TEXELS; k++) begin
      for (c = 0; c < CHANNELS; c++) begin
        acc[c] += wt[k] * store_copy[addrs[k * CHANNELS + c]];
      end
    end
    res.red   = OUT_W'(acc[0] / (64'd255 << ACC_SHIFT));
    res.green = OUT_W'(acc[1] / (64'd255 << ACC_SHIFT));
    res.blue  = OUT_W'(acc[2] / (64'd255 << ACC_SHIFT));
    return res;
  endfunction

  function void take_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TEX_WIDTH:     width_q = data;
      REG_TEX_HEIGHT:    height_q = data;
      REG_CHANNEL_COUNT: chans_q = data[CH_W-1:0];
      default: ;
    endcase
  endfunction

  // Note an accepted item: update the store or queue the blended colour
  function void take_item(tex_item_t it);
    if (it.op == OP_WRITE) begin
      store_copy[it.addr] = it.value;
      pending_colours.push_back('{1'b0, '0, '0, '0});
    end else begin
      pending_colours.push_back(blend(it.u, it.v));
    end
  endfunction

  function void compare_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Check a result transfer against the oldest outstanding colour
  function void check_colour(colour_t got);
    colour_t want;
    results_seen++;
    if (pending_colours.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, actual is_sample=%0b rgb=%0d/%0d/%0d",
               $time, got.is_sample, got.red, got.green, got.blue);
      return;
    end
    want = pending_colours.pop_front();
    compare_field("is_sample", OUT_W'(want.is_sample), OUT_W'(got.is_sample));
    compare_field("red", want.red, got.red);
    compare_field("green", want.green, got.green);
    compare_field("blue", want.blue, got.blue);
  endfunction
endclass

module tb_wrapped_texture_sampler;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned PHASES      = 15;
  localparam int unsigned PHASE_ITEMS = 70;
  localparam int unsigned DRAIN_WAIT  = 25;

  // Texture settings visited by the random part, extremes included
  localparam int unsigned PHASE_W  [PHASES] = '{4, 3, 2, 1, 4096, 8191, 0, 5, 7, 16, 1, 4096,
                                                6, 2, 3};
  localparam int unsigned PHASE_H  [PHASES] = '{4, 5, 2, 1, 4096, 8191, 5, 0, 3, 9, 4096, 1,
                                                6, 3, 3};
  localparam int unsigned PHASE_CH [PHASES] = '{1, 3, 4, 1, 4, 3, 3, 1, 2, 1, 4, 3, 7, 5, 6};

  logic clk_i = 1'b0;
  logic rst_ni;

  wts_in_if  in_chan ();
  wts_out_if out_chan ();
  wts_cfg_if cfg_chan ();

  wrapped_texture_sampler i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan),
    .cfg_chan_i (cfg_chan)
  );

  texture_mirror mirror;

  int unsigned     items_sent;
  int unsigned     writes_sent;
  int unsigned     samples_sent;
  int unsigned     black_samples;
  int unsigned     settings_used;
  int unsigned     src_idle_pct;
  int unsigned     sink_stall_pct;
  bit              byte_known [STORE_BYTES];
  int unsigned     gen_w;
  int unsigned     gen_h;
  logic [CH_W-1:0] gen_ch;
  tex_item_t       seen_item;
  colour_t         seen_colour;

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Observe transfers on all three channels
  always @(posedge clk_i) begin
    if (rst_ni && cfg_chan.valid && cfg_chan.ready) begin
      mirror.take_config(cfg_chan.index, cfg_chan.data);
    end
    if (rst_ni && in_chan.valid && in_chan.ready) begin
      seen_item.op    = opcode_e'(in_chan.opcode);
      seen_item.addr  = in_chan.byte_address;
      seen_item.value = in_chan.byte_value;
      seen_item.u     = in_chan.coord_u;
      seen_item.v     = in_chan.coord_v;
      mirror.take_item(seen_item);
    end
    if (rst_ni && out_chan.valid && out_chan.ready) begin
      seen_colour.is_sample = out_chan.is_sample;
      seen_colour.red       = out_chan.red;
      seen_colour.green     = out_chan.green;
      seen_colour.blue      = out_chan.blue;
      mirror.check_colour(seen_colour);
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", items_sent - mirror.results_seen);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic set_idling(int unsigned phase);
    case (phase % 4)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
      default: begin src_idle_pct = 21; sink_stall_pct = 21; end
    endcase
  endtask

  // Offer one item after a random gap and hold it until transfer
  task automatic send_item(tex_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_chan.valid        <= 1'b1;
    in_chan.opcode       <= it.op;
    in_chan.byte_address <= it.addr;
    in_chan.byte_value   <= it.value;
    in_chan.coord_u      <= it.u;
    in_chan.coord_v      <= it.v;
    do @(posedge clk_i); while (!in_chan.ready);
    items_sent++;
  endtask

  task automatic send_write(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] value);
    tex_item_t it;
    it.op    = OP_WRITE;
    it.addr  = addr;
    it.value = value;
    it.u     = $urandom;
    it.v     = $urandom;
    byte_known[addr] = 1'b1;
    send_item(it);
    writes_sent++;
  endtask

  // Fill any texel byte the sample would read before sending it
  task automatic send_sample(logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
    int unsigned addrs[$];
    tex_item_t   it;
    mirror.texel_addresses(gen_w, gen_h, gen_ch, u[FRAC_W-1:0], v[FRAC_W-1:0], addrs);
    if (addrs.size() == 0) black_samples++;
    foreach (addrs[n]) begin
      if (!byte_known[addrs[n]]) send_write(ADDR_W'(addrs[n]), BYTE_W'($urandom));
    end
    it.op    = OP_SAMPLE;
    it.addr  = ADDR_W'($urandom);
    it.value = BYTE_W'($urandom);
    it.u     = u;
    it.v     = v;
    send_item(it);
    samples_sent++;
  endtask

  // Bias coordinates towards zero and full fractions now and then
  function automatic logic signed [COORD_W-1:0] pick_coord();
    logic [FRAC_W-1:0] whole;
    whole = FRAC_W'($urandom);
    case ($urandom_range(7))
      0: return {whole, 16'h0000};
      1: return {whole, 16'hFFFF};
      default: return $urandom;
    endcase
  endfunction

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (mirror.results_seen != items_sent) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk_i); while (!cfg_chan.ready);
  endtask

  // Reprogram the texture once the block has gone idle
  task automatic set_texture(int unsigned w, int unsigned h, logic [CH_W-1:0] ch, bit spare);
    logic [CFG_DATA_W-1:0] ch_word;
    drain();
    ch_word = CFG_DATA_W'($urandom);
    ch_word[CH_W-1:0] = ch;
    write_reg(REG_TEX_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_TEX_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_CHANNEL_COUNT, ch_word);
    if (spare) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_chan.valid <= 1'b0;
    gen_w  = w & 13'h1FFF;
    gen_h  = h & 13'h1FFF;
    gen_ch = ch;
    settings_used++;
  endtask

  // Mostly samples over the current texture, with overwrites and stray writes
  task automatic random_phase(int unsigned count);
    int unsigned start, span, wc, hc, r;
    start = items_sent;
    wc = (gen_w > MAX_DIM) ? MAX_DIM : gen_w;
    hc = (gen_h > MAX_DIM) ? MAX_DIM : gen_h;
    span = 0;
    if (gen_ch == CH_GRAY || gen_ch == CH_RGB || gen_ch == CH_RGBA) span = wc * hc * gen_ch;
    if (span > STORE_BYTES) span = STORE_BYTES;
    while (items_sent - start < count) begin
      r = $urandom_range(99);
      if (r < 20 || (r < 30 && span == 0)) begin
        send_write(ADDR_W'($urandom), BYTE_W'($urandom));
      end else if (r < 30) begin
        send_write(ADDR_W'($urandom_range(span - 1)), BYTE_W'($urandom));
      end else begin
        send_sample(pick_coord(), pick_coord());
      end
    end
  endtask

  initial begin
    mirror = new();
    items_sent    = 0;
    writes_sent   = 0;
    samples_sent  = 0;
    black_samples = 0;
    settings_used = 0;
    gen_w  = 0;
    gen_h  = 0;
    gen_ch = '0;
    set_idling(0);
    rst_ni                = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.opcode        = 1'b0;
    in_chan.byte_address  = '0;
    in_chan.byte_value    = '0;
    in_chan.coord_u       = '0;
    in_chan.coord_v       = '0;
    cfg_chan.valid        = 1'b0;
    cfg_chan.index        = '0;
    cfg_chan.data         = '0;
    out_chan.ready        = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty texture straight after reset samples as black
    send_sample('0, '0);

    // Address and value extremes, then a small gray texture with wrap
    send_write(ADDR_W'(0), BYTE_W'(0));
    send_write(ADDR_W'(STORE_BYTES - 1), BYTE_W'(255));
    set_texture(2, 2, CH_GRAY, 1'b1);
    send_write(ADDR_W'(1), BYTE_W'(255));
    send_write(ADDR_W'(2), BYTE_W'(8'h80));
    send_write(ADDR_W'(3), BYTE_W'(8'h01));
    send_sample('0, '0);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(32'h8000_0000, 32'h0000_8000);
    send_sample(-1, -1);
    send_sample(32'hFFFF_8000, 32'h0001_4000);

    // Largest RGB texture at its far corner: neighbours and addresses wrap
    set_texture(MAX_DIM, MAX_DIM, CH_RGB, 1'b0);
    send_sample(32'h0000_FFFF, 32'h0000_FFFF);

    // Random part over a spread of texture settings and idling patterns
    for (int unsigned p = 0; p < PHASES; p++) begin
      set_idling(p);
      set_texture(PHASE_W[p], PHASE_H[p], CH_W'(PHASE_CH[p]), 1'b0);
      random_phase(PHASE_ITEMS);
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d byte writes and %0d samples (%0d black) over %0d texture settings,",
             writes_sent, samples_sent, black_samples, settings_used);
    $display("with %0d results checked and %0d mismatches.", mirror.results_seen,
             mirror.mismatches + mirror.pending_colours.size());
    if (mirror.mismatches == 0 && mirror.pending_colours.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> wrapped_texture_sampler.f
hdl/wts_pkg.sv
hdl/wts_chan_if.sv
hdl/wts_ram.sv
hdl/wts_ctrl.sv
hdl/wts_datapath.sv
hdl/wrapped_texture_sampler.sv
hdl/wts_checker.sv
dv/tb_wrapped_texture_sampler.sv
